// ----- rtl/pdks_pkg.sv -----
package pdks_pkg;

  // Capacity and field widths of the bin list
  localparam int MAX_KEEP   = 16;
  localparam int POWER_BITS = 16;
  localparam int INDEX_BITS = 12;
  localparam int AZ_BITS    = 10;
  localparam int FILL_BITS  = $clog2(MAX_KEEP + 1);

  // Configuration registers
  localparam int KEEP_BITS    = 5;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_FLOOR = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEEP_COUNT  = 1'b1;

  localparam logic [KEEP_BITS-1:0]  KEEP_COUNT_RST  = 5'd12;
  localparam logic [INDEX_BITS-1:0] RANGE_FLOOR_RST = '0;

  // One kept bin
  typedef struct packed {
    logic [POWER_BITS-1:0] power;
    logic [INDEX_BITS-1:0] index;
  } entry_t;

  // Flags one cell shows its neighbors
  typedef struct packed {
    logic lt;   // entry is valid and sorts before the candidate
    logic grp;  // entry is valid and has the weakest power of the list
  } link_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic   insert;
    logic   evict;
    logic   shift;
    entry_t cand;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

// ----- rtl/per_azimuth_k_strongest_bins_top.sv -----
// A bin is taken into the sorted list in the cycle its request is accepted.
// The results of a row start in the cycle after the row-end request and leave at one
// per cycle while out_ready_i is high; the input is held off during that drain.
// Throughput: one bin per cycle within a row; each kept bin is drained at row end.
// Reset clears the fill count and state, sets the range floor to 0 and keep_count
// to 12; the list entries themselves are not reset.
module per_azimuth_k_strongest_bins_top
  import pdks_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [AZ_BITS-1:0]       azimuth_i,
  input  logic [INDEX_BITS-1:0]    bin_index_i,
  input  logic [POWER_BITS-1:0]    power_i,
  input  logic                     row_end_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [AZ_BITS-1:0]       out_azimuth_o,
  output logic [INDEX_BITS-1:0]    out_bin_o,
  output logic                     last_of_row_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  state_e                 state_q, state_d;
  logic [FILL_BITS-1:0]   fill_q, fill_d;
  logic [INDEX_BITS-1:0]  range_floor_q;
  logic [KEEP_BITS-1:0]   keep_count_q;
  logic [AZ_BITS-1:0]     az_q;
  logic [FILL_BITS-1:0]   limit;
  logic                   in_acc, out_acc, eligible, do_ins, do_evict;
  ctl_t                   ctl;
  entry_t                 ent [MAX_KEEP];
  link_t                  lnk [MAX_KEEP];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_floor_q <= RANGE_FLOOR_RST;
      keep_count_q  <= KEEP_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_RANGE_FLOOR: range_floor_q <= cfg_wdata_i[INDEX_BITS-1:0];
        REG_KEEP_COUNT:  keep_count_q  <= cfg_wdata_i[KEEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Number of bins kept, saturated at the list capacity.
  always_comb begin
    if (int'(keep_count_q) > MAX_KEEP) begin
      limit = FILL_BITS'(MAX_KEEP);
    end else begin
      limit = FILL_BITS'(keep_count_q);
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign eligible    = bin_index_i >= range_floor_q;

  // A new bin fills a free place, or replaces the weakest kept bin when strictly stronger.
  assign do_ins   = in_acc && eligible && (limit != '0) && (fill_q < limit);
  assign do_evict = in_acc && eligible && (limit != '0) && !(fill_q < limit) &&
                    (fill_q != '0) && (power_i > ent[0].power);

  assign ctl.insert     = do_ins;
  assign ctl.evict      = do_evict;
  assign ctl.shift      = out_acc;
  assign ctl.cand.power = power_i;
  assign ctl.cand.index = bin_index_i;

  // Chain of sorted cells, weakest bin in cell 0
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    entry_t lower_e, upper_e;
    logic   lower_lt;
    link_t  upper_l;

    if (i == 0) begin : g_first
      assign lower_e  = ctl.cand;
      assign lower_lt = 1'b1;
    end else begin : g_mid
      assign lower_e  = ent[i-1];
      assign lower_lt = lnk[i-1].lt;
    end

    if (i == MAX_KEEP - 1) begin : g_last
      assign upper_e = ent[i];
      assign upper_l = '0;
    end else begin : g_inner
      assign upper_e = ent[i+1];
      assign upper_l = lnk[i+1];
    end

    pdks_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .head_power_i (ent[0].power),
      .valid_i      (FILL_BITS'(i) < fill_q),
      .lower_i      (lower_e),
      .lower_lt_i   (lower_lt),
      .upper_i      (upper_e),
      .upper_link_i (upper_l),
      .entry_o      (ent[i]),
      .link_o       (lnk[i])
    );
  end

  // Fill count and drain control
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    case (state_q)
      ST_IDLE: begin
        if (do_ins) begin
          fill_d = fill_q + FILL_BITS'(1);
        end
        if (in_acc && row_end_i && (fill_d != '0)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          fill_d = fill_q - FILL_BITS'(1);
          if (fill_q == FILL_BITS'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        fill_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  // Results carry the azimuth of the row-end request.
  always_ff @(posedge clk_i) begin
    if (in_acc && row_end_i) begin
      az_q <= azimuth_i;
    end
  end

  assign out_azimuth_o = az_q;
  assign out_bin_o     = ent[0].index;
  assign last_of_row_o = (fill_q == FILL_BITS'(1));

  // The list never holds more than its capacity.
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(fill_q) <= MAX_KEEP)
    else $error("fill count above capacity");

  // Input and output never handshake together.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input open during drain");

  // The last result of a row returns the block to taking bins with an empty list.
  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_of_row_o) |=> (in_ready_o && (fill_q == '0)))
    else $error("drain did not end cleanly");

  // The two weakest kept entries stay in emission order.
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q >= FILL_BITS'(2)) |->
      ((ent[0].power < ent[1].power) ||
       ((ent[0].power == ent[1].power) && (ent[0].index <= ent[1].index))))
    else $error("list out of order");

  // Insert and evict are never issued together.
  a_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_ins && do_evict))
    else $error("conflicting list commands");

endmodule

// ----- rtl/pdks_cell.sv -----
module pdks_cell
  import pdks_pkg::*;
(
  input  logic                  clk_i,
  input  ctl_t                  ctl_i,
  input  logic [POWER_BITS-1:0] head_power_i,
  input  logic                  valid_i,
  input  entry_t                lower_i,
  input  logic                  lower_lt_i,
  input  entry_t                upper_i,
  input  link_t                 upper_link_i,
  output entry_t                entry_o,
  output link_t                 link_o
);

  entry_t entry_q, entry_d;
  logic   lt;

  // Order is ascending power, then ascending bin index.
  assign lt = valid_i &&
              ((entry_q.power < ctl_i.cand.power) ||
               ((entry_q.power == ctl_i.cand.power) && (entry_q.index < ctl_i.cand.index)));

  assign link_o.lt  = lt;
  assign link_o.grp = valid_i && (entry_q.power == head_power_i);
  assign entry_o    = entry_q;

  // Insert opens a gap at the candidate's place by moving later entries up.
  // Evict drops the last of the weakest entries and moves the entries between
  // it and the candidate's place down by one.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = upper_i;
    end else if (ctl_i.insert) begin
      if (!lt) begin
        entry_d = lower_lt_i ? ctl_i.cand : lower_i;
      end
    end else if (ctl_i.evict) begin
      if (!upper_link_i.grp) begin
        if (upper_link_i.lt) begin
          entry_d = upper_i;
        end else if (lt) begin
          entry_d = ctl_i.cand;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- tb/strongest_bins_checker.sv -----
module strongest_bins_checker
  import pdks_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     bin_valid_i,
  input  logic                     bin_ready_i,
  input  logic [AZ_BITS-1:0]       azimuth_i,
  input  logic [INDEX_BITS-1:0]    bin_index_i,
  input  logic [POWER_BITS-1:0]    power_i,
  input  logic                     row_end_i,
  input  logic                     pick_valid_i,
  input  logic                     pick_ready_i,
  input  logic [AZ_BITS-1:0]       out_azimuth_i,
  input  logic [INDEX_BITS-1:0]    out_bin_i,
  input  logic                     last_of_row_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output int                       mismatch_count_o,
  output int                       picks_pending_o,
  output int                       picks_checked_o
);

  // One ranked bin as the block should emit it.
  typedef struct packed {
    logic [AZ_BITS-1:0]    az;
    logic [INDEX_BITS-1:0] bin;
    logic                  is_last;
  } pick_t;

  pick_t                 expected_picks[$];
  pick_t                 oldest;
  logic [INDEX_BITS-1:0] range_floor_q;
  logic [KEEP_BITS-1:0]  keep_count_q;
  logic [POWER_BITS-1:0] list_power [MAX_KEEP];
  logic [INDEX_BITS-1:0] list_bin   [MAX_KEEP];
  int                    list_fill;

  // Offer an eligible bin to the strongest-bins list of the current row.
  // A full list gives up its weakest entry (highest index among equal
  // powers) only to a strictly stronger bin.
  function automatic void offer_to_list(logic [INDEX_BITS-1:0] idx,
                                        logic [POWER_BITS-1:0] pwr);
    int limit;
    int low_slot;
    limit = (keep_count_q > MAX_KEEP) ? MAX_KEEP : int'(keep_count_q);
    if (limit == 0) return;
    if (list_fill < limit) begin
      list_power[list_fill] = pwr;
      list_bin[list_fill]   = idx;
      list_fill++;
      return;
    end
    if (list_fill == 0) return;
    low_slot = 0;
    for (int i = 1; i < list_fill; i++) begin
      if (list_power[i] < list_power[low_slot] ||
          (list_power[i] == list_power[low_slot] && list_bin[i] > list_bin[low_slot])) begin
        low_slot = i;
      end
    end
    if (pwr > list_power[low_slot]) begin
      list_power[low_slot] = pwr;
      list_bin[low_slot]   = idx;
    end
  endfunction

  // Sort the kept bins by ascending power, then ascending index, queue them
  // as expected picks and empty the list.
  function automatic void rank_row(logic [AZ_BITS-1:0] az);
    logic [POWER_BITS-1:0] sp [MAX_KEEP];
    logic [INDEX_BITS-1:0] sb [MAX_KEEP];
    pick_t                 p;
    int                    j;
    for (int i = 0; i < list_fill; i++) begin
      j = i;
      while (j > 0 && (list_power[i] < sp[j-1] ||
                       (list_power[i] == sp[j-1] && list_bin[i] < sb[j-1]))) begin
        sp[j] = sp[j-1];
        sb[j] = sb[j-1];
        j--;
      end
      sp[j] = list_power[i];
      sb[j] = list_bin[i];
    end
    for (int i = 0; i < list_fill; i++) begin
      p.az      = az;
      p.bin     = sb[i];
      p.is_last = (i == list_fill - 1);
      expected_picks = {expected_picks, p};
    end
    list_fill = 0;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    mismatch_count_o++;
  endfunction

  // Track requests on both channels and register writes at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_picks.delete();
      list_fill        = 0;
      range_floor_q    = RANGE_FLOOR_RST;
      keep_count_q     = KEEP_COUNT_RST;
      mismatch_count_o = 0;
      picks_pending_o  = 0;
      picks_checked_o  = 0;
    end else begin
      // An accepted result is held against the oldest expected pick.
      if (pick_valid_i && pick_ready_i) begin
        if (expected_picks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual az %0d bin %0d last %0b",
                   $time, out_azimuth_i, out_bin_i, last_of_row_i);
          mismatch_count_o++;
        end else begin
          oldest = expected_picks.pop_front();
          picks_checked_o++;
          if (out_azimuth_i !== oldest.az)
            note_mismatch("out_azimuth", oldest.az, out_azimuth_i);
          if (out_bin_i !== oldest.bin)
            note_mismatch("out_bin", oldest.bin, out_bin_i);
          if (last_of_row_i !== oldest.is_last)
            note_mismatch("last_of_row", oldest.is_last, last_of_row_i);
        end
      end

      // An accepted bin updates the list; a row end ranks it.
      if (bin_valid_i && bin_ready_i) begin
        if (bin_index_i >= range_floor_q) offer_to_list(bin_index_i, power_i);
        if (row_end_i) rank_row(azimuth_i);
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RANGE_FLOOR: range_floor_q = cfg_wdata_i[INDEX_BITS-1:0];
          REG_KEEP_COUNT:  keep_count_q  = cfg_wdata_i[KEEP_BITS-1:0];
          default: ;
        endcase
      end

      picks_pending_o = expected_picks.size();
    end
  end

endmodule

// ----- tb/per_azimuth_k_strongest_bins_top_tb.sv -----
module per_azimuth_k_strongest_bins_top_tb;
  import pdks_pkg::*;

  localparam int RANDOM_ITEMS = 190;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [AZ_BITS-1:0]       azimuth_i   = '0;
  logic [INDEX_BITS-1:0]    bin_index_i = '0;
  logic [POWER_BITS-1:0]    power_i     = '0;
  logic                     row_end_i   = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [AZ_BITS-1:0]       out_azimuth_o;
  logic [INDEX_BITS-1:0]    out_bin_o;
  logic                     last_of_row_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;

  int mismatch_count;
  int picks_pending;
  int picks_checked;
  int cycle_count   = 0;
  int bins_sent     = 0;
  int rows_sent     = 0;
  int random_items  = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int ready_mode    = 0;
  int mode_left     = 0;

  // State of the random row stream.
  int                    row_left     = 0;
  int                    row_idx_mode = 0;
  int                    row_pwr_mode = 0;
  logic [AZ_BITS-1:0]    row_az       = '0;
  logic [INDEX_BITS-1:0] row_next_idx = '0;

  per_azimuth_k_strongest_bins_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .azimuth_i     (azimuth_i),
    .bin_index_i   (bin_index_i),
    .power_i       (power_i),
    .row_end_i     (row_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_azimuth_o (out_azimuth_o),
    .out_bin_o     (out_bin_o),
    .last_of_row_o (last_of_row_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  strongest_bins_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .bin_valid_i      (in_valid_i),
    .bin_ready_i      (in_ready_o),
    .azimuth_i        (azimuth_i),
    .bin_index_i      (bin_index_i),
    .power_i          (power_i),
    .row_end_i        (row_end_i),
    .pick_valid_i     (out_valid_o),
    .pick_ready_i     (out_ready_i),
    .out_azimuth_i    (out_azimuth_o),
    .out_bin_i        (out_bin_o),
    .last_of_row_i    (last_of_row_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .picks_pending_o  (picks_pending),
    .picks_checked_o  (picks_checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: a long hold-off when asked for, otherwise stretches of
  // always ready, coin-flip stalls and mostly stalled.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else if (hold_requests != holds_served) begin
      holds_served++;
      hold_left   = LONG_HOLD - 1;
      out_ready_i = 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(8, 64);
      end
      mode_left--;
      case (ready_mode)
        0:       out_ready_i = 1'b1;
        1:       out_ready_i = 1'($urandom_range(0, 1));
        default: out_ready_i = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one bin request, in bursts with random gaps, and hold it until the
  // block takes it. Starts and ends at a falling edge.
  task automatic send_bin(input logic [AZ_BITS-1:0] az, input logic [INDEX_BITS-1:0] idx,
                          input logic [POWER_BITS-1:0] pwr, input logic is_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i  = 1'b1;
    azimuth_i   = az;
    bin_index_i = idx;
    power_i     = pwr;
    row_end_i   = is_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    bins_sent++;
    if (is_end) rows_sent++;
  endtask

  task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Wait until every expected result has come, then add a margin.
  task automatic drain_results();
    while (picks_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Next bin of the random row stream. Rows mostly keep one azimuth; a few
  // bins carry a stray azimuth, and some rows run past the list capacity.
  task automatic send_stream_item();
    logic [AZ_BITS-1:0]    az;
    logic [INDEX_BITS-1:0] idx;
    logic [POWER_BITS-1:0] pwr;
    if (row_left == 0) begin
      row_left     = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 48)
                                                 : $urandom_range(1, 24);
      row_az       = AZ_BITS'($urandom);
      row_next_idx = INDEX_BITS'($urandom);
      row_idx_mode = $urandom_range(0, 2);
      row_pwr_mode = $urandom_range(0, 2);
    end
    case (row_idx_mode)
      0: begin
        idx          = row_next_idx;
        row_next_idx = row_next_idx + INDEX_BITS'($urandom_range(1, 4));
      end
      1:       idx = INDEX_BITS'($urandom);
      default: idx = ($urandom_range(0, 1) == 0) ? row_next_idx : INDEX_BITS'($urandom);
    endcase
    case (row_pwr_mode)
      0: pwr = POWER_BITS'($urandom);
      1: pwr = POWER_BITS'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 2))
          0:       pwr = '0;
          1:       pwr = '1;
          default: pwr = POWER_BITS'($urandom);
        endcase
      end
    endcase
    az = row_az;
    if (row_left > 1 && $urandom_range(0, 9) == 0) az = AZ_BITS'($urandom);
    send_bin(az, idx, pwr, row_left == 1);
    row_left--;
    random_items++;
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] new_min;
    logic [CFG_DATA_BITS-1:0] new_keep;
    int                       phase_len;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Small list: ties at eviction, extreme fields, a repeated bin index and
    // a stray azimuth inside the row.
    program_reg(REG_KEEP_COUNT, CFG_DATA_BITS'(3));
    send_bin(10'h3FF, 12'd0, 16'd0, 1'b0);
    send_bin(10'h3FF, 12'hFFF, 16'hFFFF, 1'b0);
    send_bin(10'h000, 12'd10, 16'd100, 1'b0);
    send_bin(10'h3FF, 12'd20, 16'd100, 1'b0);
    send_bin(10'h3FF, 12'd10, 16'd300, 1'b0);
    send_bin(10'h3FF, 12'd7, 16'd100, 1'b1);

    // Highest range limit: a row with no eligible bin, then one exactly at it.
    drain_results();
    program_reg(REG_RANGE_FLOOR, 12'hFFF);
    program_reg(REG_KEEP_COUNT, CFG_DATA_BITS'(12));
    send_bin(10'd5, 12'hFFE, 16'hFFFF, 1'b1);
    send_bin(10'd5, 12'hFFF, 16'd0, 1'b1);

    // Zero keep count keeps nothing.
    drain_results();
    program_reg(REG_RANGE_FLOOR, 12'd0);
    program_reg(REG_KEEP_COUNT, CFG_DATA_BITS'(0));
    send_bin(10'd0, 12'd0, 16'hFFFF, 1'b1);

    // Keep count above capacity saturates; narrow powers force many ties.
    drain_results();
    program_reg(REG_KEEP_COUNT, CFG_DATA_BITS'(31));
    for (int i = 0; i < 17; i++) begin
      send_bin(10'h2AA, INDEX_BITS'(i * 241), POWER_BITS'($urandom_range(0, 7)), i == 16);
    end

    // Random phases. Settings change at phase edges, which usually fall
    // inside a row, so limits also move while a list is partly full.
    for (int phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      drain_results();
      case (phase)
        0: begin new_min = 12'd0;    new_keep = CFG_DATA_BITS'(16); end
        1: begin new_min = 12'd0;    new_keep = CFG_DATA_BITS'(1);  end
        2: begin new_min = 12'hFFF;  new_keep = CFG_DATA_BITS'(16); end
        3: begin new_min = 12'd2048; new_keep = CFG_DATA_BITS'(31); end
        4: begin new_min = CFG_DATA_BITS'($urandom); new_keep = CFG_DATA_BITS'(0); end
        5: begin new_min = 12'd0;    new_keep = CFG_DATA_BITS'(17); end
        default: begin
          new_min  = CFG_DATA_BITS'($urandom_range(0, 1023));
          new_keep = ($urandom_range(0, 5) == 0) ? CFG_DATA_BITS'($urandom_range(17, 31))
                                                 : CFG_DATA_BITS'($urandom_range(1, 16));
        end
      endcase
      program_reg(REG_RANGE_FLOOR, new_min);
      program_reg(REG_KEEP_COUNT, new_keep);
      // Stall results for a long stretch while bins keep coming.
      if (phase == 0) hold_requests++;
      phase_len = $urandom_range(20, 40);
      repeat (phase_len) send_stream_item();
    end
    while (row_left != 0) send_stream_item();

    drain_results();
    repeat (20) @(negedge clk_i);

    $display("Sent %0d bins with %0d row-end requests; %0d ranked bins were compared.",
             bins_sent, rows_sent, picks_checked);
    $display("Keep counts from 0 to 31 and range limits from 0 to 4095 were used, "
             , "with one long output stall.");
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- per_azimuth_k_strongest_bins_top.f -----
rtl/pdks_pkg.sv
rtl/pdks_cell.sv
rtl/per_azimuth_k_strongest_bins_top.sv
tb/strongest_bins_checker.sv
tb/per_azimuth_k_strongest_bins_top_tb.sv
